>>> sv/rdc_pkg.sv
// Shared types, constants and helpers for the radix digit converter.
// No dependencies; every other file takes what it needs by scoped name.
`default_nettype none

package rdc_pkg;

    // Field widths
    localparam int NUM_W   = 63;
    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;

    // Radix limits and reset value
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

    // Stack depth default and the cap on digits per number
    localparam int MAX_DIGITS_DEF = 64;
    localparam int RESULT_LIMIT   = 63;

    // Divider: dividend bits consumed per cycle, padded dividend width
    localparam int DIV_STEP  = 8;
    localparam int DIV_W     = ((NUM_W + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
    localparam int DIV_CYC   = DIV_W / DIV_STEP;
    localparam int DIV_CNT_W = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(8'h41);

    // One queued conversion: the number and the base already saturated
    typedef struct packed {
        logic [NUM_W-1:0]   value;
        logic [RADIX_W-1:0] base;
    } t_job;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(10)) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DIGIT_W'(10));
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> sv/rdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rdc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/rdc_front.sv
// Input side: takes numbers, saturates the radix and holds them in a two-entry queue.
// Depends on rdc_pkg.
`default_nettype none

module rdc_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic [rdc_pkg::NUM_W-1:0]     i_number_value,
    input  wire logic [rdc_pkg::RADIX_W-1:0]   i_radix,
    output logic                               o_job_valid,
    output rdc_pkg::t_job                      o_job,
    input  wire logic                          i_job_pop
);

    rdc_pkg::t_job                r_q [2];
    logic                         r_wr_ptr;
    logic                         r_rd_ptr;
    logic [1:0]                   r_cnt;
    logic [rdc_pkg::RADIX_W-1:0]  base_sat;
    logic                         do_push;
    logic                         do_pop;

    // Clamp the base into 2..16
    always_comb begin
        if (i_radix < rdc_pkg::RADIX_MIN) begin
            base_sat = rdc_pkg::RADIX_MIN;
        end else if (i_radix > rdc_pkg::RADIX_MAX) begin
            base_sat = rdc_pkg::RADIX_MAX;
        end else begin
            base_sat = i_radix;
        end
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_job_pop && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr].value <= i_number_value;
            r_q[r_wr_ptr].base  <= base_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/rdc_back.sv
// Conversion engine: digit-by-digit divider, digit stack and character output register.
// Depends on rdc_pkg and rdc_ram.
`default_nettype none

module rdc_back #(
    parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_job_valid,
    input  wire rdc_pkg::t_job                 i_job,
    output logic                               o_job_pop,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output logic      [rdc_pkg::CHAR_W-1:0]    o_digit_char,
    output logic                               o_last_digit
);

    localparam int ADDR_W = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int LIMIT_I = (MAX_DIGITS < rdc_pkg::RESULT_LIMIT) ?
                             MAX_DIGITS : rdc_pkg::RESULT_LIMIT;
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(LIMIT_I);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_READ = 4'b0100,
        ST_LOAD = 4'b1000
    } t_state;

    t_state                             r_state, n_state;
    logic [rdc_pkg::DIV_W-1:0]          r_work, n_work;
    logic [rdc_pkg::RADIX_W-1:0]        r_base, n_base;
    logic [rdc_pkg::DIGIT_W-1:0]        r_rem, n_rem;
    logic [rdc_pkg::DIV_CNT_W-1:0]      r_step, n_step;
    logic [CNT_W-1:0]                   r_count, n_count;
    logic                               r_last, n_last;
    logic                               r_out_valid, n_out_valid;
    logic [rdc_pkg::CHAR_W-1:0]         r_out_char, n_out_char;
    logic                               r_out_last, n_out_last;

    logic [rdc_pkg::DIGIT_W-1:0]        step_rem;
    logic [rdc_pkg::DIV_STEP-1:0]       step_q;
    logic [rdc_pkg::DIV_W-1:0]          step_work;
    logic [CNT_W-1:0]                   count_inc;

    logic                               wr_en;
    logic                               rd_en;
    logic [ADDR_W-1:0]                  rd_addr;
    logic [rdc_pkg::DIGIT_W-1:0]        rd_data;
    logic                               out_take;

    // Eight restoring-division bit steps on the top byte of the work word
    always_comb begin
        logic [rdc_pkg::RADIX_W-1:0] t;
        logic [rdc_pkg::DIGIT_W-1:0] rem;
        rem    = r_rem;
        step_q = '0;
        for (int i = rdc_pkg::DIV_STEP - 1; i >= 0; i--) begin
            t = {rem, r_work[rdc_pkg::DIV_W - rdc_pkg::DIV_STEP + i]};
            if (t >= r_base) begin
                t         = t - r_base;
                step_q[i] = 1'b1;
            end
            rem = t[rdc_pkg::DIGIT_W-1:0];
        end
        step_rem  = rem;
        step_work = {r_work[rdc_pkg::DIV_W-rdc_pkg::DIV_STEP-1:0], step_q};
    end

    assign count_inc = r_count + CNT_W'(1);
    assign out_take  = i_pop && r_out_valid;
    assign wr_en     = (r_state == ST_DIV) &&
                       (r_step == rdc_pkg::DIV_CNT_W'(rdc_pkg::DIV_CYC - 1));
    assign rd_addr   = ADDR_W'(r_count - CNT_W'(1));

    always_comb begin
        n_state     = r_state;
        n_work      = r_work;
        n_base      = r_base;
        n_rem       = r_rem;
        n_step      = r_step;
        n_count     = r_count;
        n_last      = r_last;
        n_out_valid = r_out_valid && !out_take;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_job_pop   = 1'b0;
        rd_en       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_work    = {{(rdc_pkg::DIV_W - rdc_pkg::NUM_W){1'b0}}, i_job.value};
                    n_base    = i_job.base;
                    n_rem     = '0;
                    n_step    = '0;
                    n_count   = '0;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                n_step = r_step + rdc_pkg::DIV_CNT_W'(1);
                if (wr_en) begin
                    // Digit done: push remainder, carry on with the quotient
                    n_count = count_inc;
                    n_work  = step_work;
                    n_rem   = '0;
                    n_step  = '0;
                    if (!((|step_work) && (count_inc < LIMIT))) begin
                        n_state = ST_READ;
                    end
                end else begin
                    n_work = step_work;
                    n_rem  = step_rem;
                end
            end
            ST_READ: begin
                if (!r_out_valid || i_pop) begin
                    rd_en   = 1'b1;
                    n_last  = (r_count == CNT_W'(1));
                    n_count = r_count - CNT_W'(1);
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_out_valid = 1'b1;
                n_out_char  = rdc_pkg::digit_to_ascii(rd_data);
                n_out_last  = r_last;
                n_state     = r_last ? ST_IDLE : ST_READ;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    rdc_ram #(
        .WIDTH (rdc_pkg::DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (step_rem),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        r_work     <= n_work;
        r_base     <= n_base;
        r_rem      <= n_rem;
        r_step     <= n_step;
        r_last     <= n_last;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last_digit = r_out_last;

endmodule

`default_nettype wire

>>> sv/radix_digit_converter_top.sv
// Top level of the radix digit converter: radix register, input queue, conversion engine.
// Depends on rdc_pkg, rdc_front, rdc_back (and rdc_ram below it).
`default_nettype none

// Converts a 63-bit non-negative integer into ASCII digits of a base from 2 to 16,
// most significant digit first, with the final digit flagged by o_last_digit; zero
// gives the single character '0'. The base comes from a 5-bit register (reset 10),
// written through i_cfg_we/i_cfg_wdata; values below 2 act as 2 and above 16 as 16.
// Numbers enter through a two-entry queue (push/full), so up to two can wait while
// the engine works. The engine takes one number at a time: its divider retires 8
// dividend bits per cycle against the base to produce each digit, and each character
// is then fetched from the registered digit stack and loaded into the output register
// (empty/pop). At most min(MAX_DIGITS, 63) least significant digits are produced.

module radix_digit_converter_top #(
    parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Number input
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [rdc_pkg::NUM_W-1:0]     i_number_value,
    // Character output
    output logic                               empty,
    input  wire logic                          pop,
    output logic      [rdc_pkg::CHAR_W-1:0]    o_digit_char,
    output logic                               o_last_digit,
    // Radix register
    input  wire logic                          i_cfg_we,
    input  wire logic [rdc_pkg::RADIX_W-1:0]   i_cfg_wdata
);

    logic [rdc_pkg::RADIX_W-1:0] r_radix;
    logic                        job_valid;
    logic                        job_pop;
    rdc_pkg::t_job               job;

    // Hold the radix; write it only between conversions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= rdc_pkg::RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_wdata;
        end
    end

    // Front: transfer numbers in, attach the clamped base, queue them
    rdc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_number_value (i_number_value),
        .i_radix        (r_radix),
        .o_job_valid    (job_valid),
        .o_job          (job),
        .i_job_pop      (job_pop)
    );

    // Back: divide into digits, stack them, then emit them as characters
    rdc_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (job_valid),
        .i_job        (job),
        .o_job_pop    (job_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

endmodule

`default_nettype wire

>>> bench/radix_digit_converter_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for radix_digit_converter_top: numbers in, ASCII digits out.
// Depends on rdc_pkg for widths and character codes; needs only the RTL to build.

module radix_digit_converter_top_tb;

    localparam int NUM_W          = rdc_pkg::NUM_W;
    localparam int RADIX_W        = rdc_pkg::RADIX_W;
    localparam int DIGIT_W        = rdc_pkg::DIGIT_W;
    localparam int CHAR_W         = rdc_pkg::CHAR_W;
    localparam int MAX_DIGITS_DEF = rdc_pkg::MAX_DIGITS_DEF;
    localparam int RESULT_LIMIT   = rdc_pkg::RESULT_LIMIT;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = rdc_pkg::RADIX_MIN;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = rdc_pkg::RADIX_MAX;
    localparam logic [RADIX_W-1:0] RADIX_RESET = rdc_pkg::RADIX_RESET;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = rdc_pkg::CHAR_ZERO;
    localparam logic [CHAR_W-1:0]  CHAR_A      = rdc_pkg::CHAR_A;

    localparam int RESET_CYCLES   = 9;
    localparam int DIGIT_CAP      = (MAX_DIGITS_DEF < RESULT_LIMIT) ? MAX_DIGITS_DEF
                                                                    : RESULT_LIMIT;
    // Longest stretch the receiver refuses every character to force backpressure
    localparam int HOLD_CYCLES    = 400;
    // Wait after draining, sized for a 63-digit binary conversion with some margin
    localparam int DRAIN_CYCLES   = 700;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_ITEMS    = 50;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } t_digit_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [NUM_W-1:0]      i_number_value;
    logic                  empty;
    logic                  pop;
    logic [CHAR_W-1:0]     o_digit_char;
    logic                  o_last_digit;
    logic                  i_cfg_we;
    logic [RADIX_W-1:0]    i_cfg_wdata;

    logic [NUM_W-1:0]      pending_numbers [$];
    t_digit_result         expected_chars [$];
    logic [RADIX_W-1:0]    radix_shadow;

    // Handshake flags from the edge monitor, read by the drivers at the next falling edge
    logic                  took_number;
    logic                  took_char;
    logic                  calm_tail;

    int                    hold_requests;
    int                    hold_served;
    int                    hold_left;
    int                    send_gap;
    int                    recv_gap;
    int                    errors;
    int                    numbers_sent;
    int                    chars_checked;
    int                    radix_writes;
    int                    quiet_cycles;

    radix_digit_converter_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_number_value (i_number_value),
        .empty          (empty),
        .pop            (pop),
        .o_digit_char   (o_digit_char),
        .o_last_digit   (o_last_digit),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Work out the characters one number turns into under the current radix register,
    // most significant digit first, and append them to the expected store.
    function automatic void convert_number(input logic [NUM_W-1:0] value,
                                           input logic [RADIX_W-1:0] radix_reg);
        logic [NUM_W-1:0]   rest;
        logic [NUM_W-1:0]   base;
        logic [DIGIT_W-1:0] digits [$];
        logic [DIGIT_W-1:0] d;
        t_digit_result      r;
        // Saturate the base into 2..16 so the loop ends and every digit has a character
        if (radix_reg < RADIX_MIN) begin
            base = NUM_W'(RADIX_MIN);
        end else if (radix_reg > RADIX_MAX) begin
            base = NUM_W'(RADIX_MAX);
        end else begin
            base = NUM_W'(radix_reg);
        end
        rest = value;
        // Zero still yields one digit, hence test after the first division
        do begin
            digits.push_back(DIGIT_W'(rest % base));
            rest = rest / base;
        end while (rest != '0 && digits.size() < DIGIT_CAP);
        for (int i = digits.size() - 1; i >= 0; i--) begin
            d = digits[i];
            if (d < DIGIT_W'(10)) begin
                r.code = CHAR_ZERO + CHAR_W'(d);
            end else begin
                r.code = CHAR_A + CHAR_W'(d - DIGIT_W'(10));
            end
            r.is_last = (i == 0);
            expected_chars.push_back(r);
        end
    endfunction

    // Monitor: sample every transfer at the rising edge. Handle the output side first
    // so a character can never be matched against a prediction made at the same edge.
    always @(posedge i_clk) begin
        t_digit_result want;
        took_number = 1'b0;
        took_char   = 1'b0;
        if (!i_rst_n) begin
            radix_shadow = RADIX_RESET;
        end else begin
            if (pop && !empty) begin
                took_char = 1'b1;
                if (expected_chars.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected character: expected none, actual 0x%02h last %0b",
                             $time, o_digit_char, o_last_digit);
                end else begin
                    want = expected_chars.pop_front();
                    chars_checked++;
                    if (o_digit_char !== want.code) begin
                        errors++;
                        $display("%0t: digit_char mismatch: expected 0x%02h, actual 0x%02h",
                                 $time, want.code, o_digit_char);
                    end
                    if (o_last_digit !== want.is_last) begin
                        errors++;
                        $display("%0t: last_digit mismatch: expected %0b, actual %0b",
                                 $time, want.is_last, o_last_digit);
                    end
                end
            end
            if (i_cfg_we) begin
                radix_shadow = i_cfg_wdata;
            end
            if (push && !full) begin
                took_number = 1'b1;
                numbers_sent++;
                convert_number(i_number_value, radix_shadow);
                void'(pending_numbers.pop_front());
            end
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired after %0d cycles without a transfer",
                     $time, quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Sender: hold an offer until it transfers, then present the next pending number,
    // now and then after a random gap. Put noise on the data while push is low.
    always @(negedge i_clk) begin
        logic             nxt_push;
        logic [NUM_W-1:0] nxt_value;
        nxt_push  = push;
        nxt_value = i_number_value;
        if (!i_rst_n) begin
            nxt_push = 1'b0;
        end else if (!(push && !took_number)) begin
            if (took_number && !calm_tail && $urandom_range(0, 3) == 0) begin
                send_gap = $urandom_range(1, 13);
            end
            if (send_gap > 0) begin
                send_gap--;
                nxt_push = 1'b0;
            end else if (pending_numbers.size() > 0) begin
                nxt_push  = 1'b1;
                nxt_value = pending_numbers[0];
            end else begin
                nxt_push = 1'b0;
            end
            if (!nxt_push) begin
                nxt_value = NUM_W'({$urandom, $urandom});
            end
        end
        push           <= nxt_push;
        i_number_value <= nxt_value;
    end

    // Receiver: stall in random bursts, and serve a long hold-off whenever one is asked
    always @(negedge i_clk) begin
        logic nxt_pop;
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (took_char && !calm_tail && $urandom_range(0, 4) == 0) begin
            recv_gap = $urandom_range(1, 13);
        end
        if (!i_rst_n) begin
            nxt_pop = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            nxt_pop = 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            nxt_pop = 1'b0;
        end else begin
            nxt_pop = 1'b1;
        end
        pop <= nxt_pop;
    end

    // Wait until every queued number has transferred and every character has arrived
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_numbers.size() != 0 || expected_chars.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Write the radix register while the converter is idle
    task automatic write_radix(input logic [RADIX_W-1:0] value);
        wait_drained();
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        radix_writes++;
    endtask

    initial begin
        int               nbits;
        logic [63:0]      raw;
        logic [NUM_W-1:0] mask;
        logic [RADIX_W-1:0] phase_radix;

        i_rst_n        = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;
        i_number_value = '0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        took_number    = 1'b0;
        took_char      = 1'b0;
        calm_tail      = 1'b0;
        hold_requests  = 0;
        hold_served    = 0;
        hold_left      = 0;
        send_gap       = 0;
        recv_gap       = 0;
        errors         = 0;
        numbers_sent   = 0;
        chars_checked  = 0;
        radix_writes   = 0;
        quiet_cycles   = 0;
        radix_shadow   = RADIX_RESET;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset radix of ten: zero, single digits, the carry into two digits, full width
        pending_numbers.push_back(NUM_W'(0));
        pending_numbers.push_back(NUM_W'(1));
        pending_numbers.push_back(NUM_W'(9));
        pending_numbers.push_back(NUM_W'(10));
        pending_numbers.push_back(NUM_W'(64'd999999999999999999));
        pending_numbers.push_back(63'h7FFF_FFFF_FFFF_FFFF);

        // Binary: the widest conversion, sixty-three digits
        write_radix(RADIX_W'(2));
        pending_numbers.push_back(63'h7FFF_FFFF_FFFF_FFFF);
        pending_numbers.push_back(63'h4000_0000_0000_0000);
        pending_numbers.push_back(NUM_W'(0));
        pending_numbers.push_back(NUM_W'(1));

        // Hexadecimal: every letter digit
        write_radix(RADIX_W'(16));
        pending_numbers.push_back(63'h7FFF_FFFF_FFFF_FFFF);
        pending_numbers.push_back(63'h0123_4567_89AB_CDEF);
        pending_numbers.push_back(NUM_W'(15));
        pending_numbers.push_back(NUM_W'(16));

        // Radix below two saturates to binary
        write_radix(RADIX_W'(0));
        pending_numbers.push_back(NUM_W'(5));
        write_radix(RADIX_W'(1));
        pending_numbers.push_back(NUM_W'(6));

        // Radix above sixteen saturates to hexadecimal
        write_radix(RADIX_W'(17));
        pending_numbers.push_back(NUM_W'(255));
        write_radix(RADIX_W'(31));
        pending_numbers.push_back(63'h7FFF_FFFF_FFFF_FFFF);

        write_radix(RADIX_W'(3));
        pending_numbers.push_back(63'h7FFF_FFFF_FFFF_FFFF);

        // Random phases: mostly short numbers, some up to full width
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: phase_radix = RADIX_W'(2);
                1: phase_radix = RADIX_W'(16);
                2: phase_radix = RADIX_W'(0);
                3: phase_radix = RADIX_W'(31);
                default: phase_radix = RADIX_W'($urandom_range(0, 31));
            endcase
            write_radix(phase_radix);
            // Drop idling for the final phase
            if (phase == RANDOM_PHASES - 1) begin
                calm_tail = 1'b1;
            end
            // Hold off the receiver while numbers keep coming, so the input stalls
            if (phase == 1) begin
                hold_requests++;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                nbits = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 20)
                                                   : $urandom_range(1, NUM_W);
                raw   = {$urandom, $urandom};
                mask  = (NUM_W'(1) << nbits) - NUM_W'(1);
                pending_numbers.push_back(raw[NUM_W-1:0] & mask);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_chars.size() != 0) begin
            errors++;
            $display("%0t: %0d expected characters never arrived",
                     $time, expected_chars.size());
        end
        $display("Converted %0d numbers into %0d checked characters across %0d radix writes,",
                 numbers_sent, chars_checked, radix_writes);
        $display("including saturating radix values and a long receiver hold-off; %0d errors.",
                 errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
